@@ sv/wwsc_pkg.sv @@
`default_nettype none
// ============================================================================
// wwsc_pkg
// Shared widths and interface structs for the windowed weighted square-count
// sum block.
// ============================================================================
package wwsc_pkg;

    localparam int POS_W   = 12;          // array index width
    localparam int VAL_W   = 16;          // element value width
    localparam int WIN_W   = POS_W + 1;   // window pointers, hold 0..2^POS_W
    localparam int CNT_W   = POS_W + 1;   // histogram count, at most 2^POS_W
    localparam int TOTAL_W = 40;          // running total, wraps
    localparam int PROD_W  = CNT_W + 1 + VAL_W;

    // histogram update request, one cycle pulse
    typedef struct packed {
        logic             valid;
        logic             remove;
        logic [VAL_W-1:0] value;
    } hist_req_t;

    // histogram update result, registered after the histogram read and count update
    typedef struct packed {
        logic              skip;
        logic              remove;
        logic [PROD_W-1:0] delta;
    } hist_rsp_t;

endpackage
`default_nettype wire

@@ sv/wwsc_hist.sv @@
`default_nettype none
// ============================================================================
// wwsc_hist
// Value histogram in one synchronous memory. Clears itself after reset, one
// entry a cycle, then serves add/remove read-modify-write requests.
// ============================================================================
module wwsc_hist #(
    parameter int VALUE_RANGE = 65536
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wwsc_pkg::hist_req_t req,
    output wwsc_pkg::hist_rsp_t rsp,
    output logic                clear_done
);

    localparam int HIST_DEPTH = (VALUE_RANGE < (1 << wwsc_pkg::VAL_W)) ?
                                VALUE_RANGE : (1 << wwsc_pkg::VAL_W);
    localparam int HIST_AW    = $clog2(HIST_DEPTH);

    logic [wwsc_pkg::CNT_W-1:0] hist_mem [HIST_DEPTH];

    logic                        clr_busy_reg;
    logic [HIST_AW-1:0]          clr_addr_reg;
    logic                        pend_valid_reg;
    logic                        pend_rem_reg;
    logic [wwsc_pkg::VAL_W-1:0]  pend_val_reg;
    logic [wwsc_pkg::CNT_W-1:0]  hist_q_reg;
    wwsc_pkg::hist_rsp_t         rsp_reg;

    logic                        oor;
    logic                        skip;
    logic [wwsc_pkg::CNT_W-1:0]  cnt_dec;
    logic [wwsc_pkg::CNT_W-1:0]  cnt_new;
    logic [wwsc_pkg::CNT_W:0]    factor;
    logic [wwsc_pkg::PROD_W-1:0] prod;
    logic                        hist_we;
    logic [HIST_AW-1:0]          hist_waddr;
    logic [wwsc_pkg::CNT_W-1:0]  hist_wdata;

    always_comb begin
        oor     = 32'(pend_val_reg) >= VALUE_RANGE;
        skip    = oor || (pend_rem_reg && (hist_q_reg == '0));
        cnt_dec = hist_q_reg - 1'b1;
        cnt_new = pend_rem_reg ? cnt_dec : hist_q_reg + 1'b1;
        // 2c+1 on add, 2c-1 on remove
        factor  = {(pend_rem_reg ? cnt_dec : hist_q_reg), 1'b1};
        prod    = wwsc_pkg::PROD_W'(factor) * wwsc_pkg::PROD_W'(pend_val_reg);

        hist_we    = clr_busy_reg || (pend_valid_reg && !skip);
        hist_waddr = clr_busy_reg ? clr_addr_reg : pend_val_reg[HIST_AW-1:0];
        hist_wdata = clr_busy_reg ? '0 : cnt_new;
    end

    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        hist_q_reg <= hist_mem[req.value[HIST_AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg   <= 1'b1;
            clr_addr_reg   <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            pend_valid_reg <= req.valid;
            if (clr_busy_reg) begin
                if (clr_addr_reg == HIST_AW'(HIST_DEPTH - 1)) begin
                    clr_busy_reg <= 1'b0;
                end else begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.valid) begin
            pend_rem_reg <= req.remove;
            pend_val_reg <= req.value;
        end
        if (pend_valid_reg) begin
            rsp_reg.skip   <= skip;
            rsp_reg.remove <= pend_rem_reg;
            rsp_reg.delta  <= prod;
        end
    end

    assign rsp        = rsp_reg;
    assign clear_done = !clr_busy_reg;

endmodule
`default_nettype wire

@@ sv/window_weighted_square_count_sum.sv @@
`default_nettype none
// ============================================================================
// window_weighted_square_count_sum
// Stored array with a sliding window and a running sum of count^2 * value.
// ============================================================================
// Input channel s_*: tuser = mode (0 load, 1 query). A load writes one array
// element; if it lies inside the current window the histogram and total are
// updated. A query moves the window ends one position at a time to
// [left_bound, right_bound] and returns the total on m_*; tuser = bad_query.
// Loads give no output transaction; out-of-range loads are dropped. A bad
// query returns total 0, bad 1. A load outside the window is written on
// accept and s_tready stays high for the next item; a load inside it and a
// query hold s_tready low until they are done, a rejected query moving no end.
// Each move is an element read, a histogram read, a count update with a
// multiply and an accumulate, through one read and one write port per memory.
// After reset the histogram is cleared, one entry a cycle, over all
// min(VALUE_RANGE, 65536) entries; s_tready stays low until then.
// A result waits in the output register while m_tready is low; loads keep
// being taken, and a query finishing then waits until the register frees.
// ============================================================================
module window_weighted_square_count_sum #(
    parameter int ARRAY_DEPTH = 4096,
    parameter int VALUE_RANGE = 65536
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // [11:0] position, [27:12] element_value, [39:28] left_bound,
    // [51:40] right_bound, [55:52] zero
    input  wire  [55:0] s_tdata,
    // [0] mode
    input  wire  [0:0]  s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    // [39:0] window_total
    output logic [39:0] m_tdata,
    // [0] bad_query
    output logic [0:0]  m_tuser
);

    localparam int ELEM_DEPTH = (ARRAY_DEPTH < (1 << wwsc_pkg::POS_W)) ?
                                ARRAY_DEPTH : (1 << wwsc_pkg::POS_W);
    localparam int EAW        = $clog2(ELEM_DEPTH);
    localparam int WIN_W      = wwsc_pkg::WIN_W;

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_CLEAR = 3'd0;
    localparam logic [ST_W-1:0] ST_IDLE  = 3'd1;
    localparam logic [ST_W-1:0] ST_NEXT  = 3'd2;
    localparam logic [ST_W-1:0] ST_ELEM  = 3'd3;
    localparam logic [ST_W-1:0] ST_HREQ  = 3'd4;
    localparam logic [ST_W-1:0] ST_HWAIT = 3'd5;
    localparam logic [ST_W-1:0] ST_ACC   = 3'd6;
    localparam logic [ST_W-1:0] ST_DONE  = 3'd7;

    logic [wwsc_pkg::POS_W-1:0] s_pos, s_lq, s_rq;
    logic [wwsc_pkg::VAL_W-1:0] s_val;
    logic                       s_query;

    assign s_pos   = s_tdata[11:0];
    assign s_val   = s_tdata[27:12];
    assign s_lq    = s_tdata[39:28];
    assign s_rq    = s_tdata[51:40];
    assign s_query = s_tuser[0];

    // control state
    logic [ST_W-1:0]              state_reg, state_next;
    logic [WIN_W-1:0]             left_reg, left_next;
    logic [WIN_W-1:0]             rp1_reg, rp1_next;       // window_right + 1
    logic [wwsc_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic                         m_valid_reg, m_valid_next;

    // payload
    logic [EAW-1:0]               addr_reg, addr_next;
    logic [wwsc_pkg::VAL_W-1:0]   val_reg, val_next;
    logic [wwsc_pkg::POS_W-1:0]   lq_reg, lq_next;
    logic [wwsc_pkg::POS_W-1:0]   rq_reg, rq_next;
    logic                         load_reg, load_next;
    logic                         phase2_reg, phase2_next;  // load: add new value
    logic                         rem_reg, rem_next;
    logic                         bad_reg, bad_next;
    logic [wwsc_pkg::TOTAL_W-1:0] m_total_reg, m_total_next;
    logic                         m_bad_reg, m_bad_next;

    logic [wwsc_pkg::VAL_W-1:0] elem_mem [ELEM_DEPTH];
    logic [wwsc_pkg::VAL_W-1:0] elem_rd_q;
    logic                       elem_we;
    logic [EAW-1:0]             elem_waddr;
    logic [wwsc_pkg::VAL_W-1:0] elem_wdata;

    wwsc_pkg::hist_req_t hist_req;
    wwsc_pkg::hist_rsp_t hist_rsp;
    logic                hist_ready;

    logic             accept;
    logic             load_ignore;
    logic             in_window;
    logic             query_bad;
    logic [WIN_W-1:0] lq13, rq13, rqp1, left_dec, rp1_dec;

    wwsc_hist #(
        .VALUE_RANGE (VALUE_RANGE)
    ) u_hist (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req        (hist_req),
        .rsp        (hist_rsp),
        .clear_done (hist_ready)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign hist_req.valid  = (state_reg == ST_HREQ);
    assign hist_req.remove = rem_reg;
    assign hist_req.value  = phase2_reg ? val_reg : elem_rd_q;

    always_ff @(posedge aclk) begin
        if (elem_we) begin
            elem_mem[elem_waddr] <= elem_wdata;
        end
        elem_rd_q <= elem_mem[addr_reg];
    end

    always_comb begin
        load_ignore = (32'(s_pos) >= ARRAY_DEPTH) || (32'(s_val) >= VALUE_RANGE);
        in_window   = ({1'b0, s_pos} >= left_reg) && ({1'b0, s_pos} < rp1_reg);
        query_bad   = (s_lq > s_rq) || (32'(s_rq) >= ARRAY_DEPTH);
        lq13        = {1'b0, lq_reg};
        rq13        = {1'b0, rq_reg};
        rqp1        = rq13 + 1'b1;
        left_dec    = left_reg - 1'b1;
        rp1_dec     = rp1_reg - 1'b1;

        state_next   = state_reg;
        left_next    = left_reg;
        rp1_next     = rp1_reg;
        total_next   = total_reg;
        m_valid_next = m_valid_reg;
        addr_next    = addr_reg;
        val_next     = val_reg;
        lq_next      = lq_reg;
        rq_next      = rq_reg;
        load_next    = load_reg;
        phase2_next  = phase2_reg;
        rem_next     = rem_reg;
        bad_next     = bad_reg;
        m_total_next = m_total_reg;
        m_bad_next   = m_bad_reg;
        elem_we      = 1'b0;
        elem_waddr   = addr_reg;
        elem_wdata   = val_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                if (hist_ready) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    val_next    = s_val;
                    lq_next     = s_lq;
                    rq_next     = s_rq;
                    addr_next   = s_pos[EAW-1:0];
                    load_next   = !s_query;
                    phase2_next = 1'b0;
                    if (s_query) begin
                        bad_next   = query_bad;
                        state_next = query_bad ? ST_DONE : ST_NEXT;
                    end else if (!load_ignore) begin
                        if (in_window) begin
                            rem_next   = 1'b1;   // take out the old element first
                            state_next = ST_ELEM;
                        end else begin
                            elem_we    = 1'b1;
                            elem_waddr = s_pos[EAW-1:0];
                            elem_wdata = s_val;
                        end
                    end
                end
            end
            ST_NEXT: begin
                // extend both ends before shrinking either
                if (left_reg > lq13) begin
                    left_next  = left_dec;
                    addr_next  = left_dec[EAW-1:0];
                    rem_next   = 1'b0;
                    state_next = ST_ELEM;
                end else if (rp1_reg <= rq13) begin
                    rp1_next   = rp1_reg + 1'b1;
                    addr_next  = rp1_reg[EAW-1:0];
                    rem_next   = 1'b0;
                    state_next = ST_ELEM;
                end else if (left_reg < lq13) begin
                    left_next  = left_reg + 1'b1;
                    addr_next  = left_reg[EAW-1:0];
                    rem_next   = 1'b1;
                    state_next = ST_ELEM;
                end else if (rp1_reg > rqp1) begin
                    rp1_next   = rp1_dec;
                    addr_next  = rp1_dec[EAW-1:0];
                    rem_next   = 1'b1;
                    state_next = ST_ELEM;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_ELEM: begin
                state_next = ST_HREQ;
            end
            ST_HREQ: begin
                state_next = ST_HWAIT;
            end
            ST_HWAIT: begin
                state_next = ST_ACC;
            end
            ST_ACC: begin
                if (!hist_rsp.skip) begin
                    if (hist_rsp.remove) begin
                        total_next = total_reg - wwsc_pkg::TOTAL_W'(hist_rsp.delta);
                    end else begin
                        total_next = total_reg + wwsc_pkg::TOTAL_W'(hist_rsp.delta);
                    end
                end
                if (!load_reg) begin
                    state_next = ST_NEXT;
                end else if (!phase2_reg) begin
                    // old value is out, store the new one and add it
                    elem_we     = 1'b1;
                    phase2_next = 1'b1;
                    rem_next    = 1'b0;
                    state_next  = ST_HREQ;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_total_next = bad_reg ? '0 : total_reg;
                    m_bad_next   = bad_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            left_reg    <= '0;
            rp1_reg     <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            left_reg    <= left_next;
            rp1_reg     <= rp1_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg    <= addr_next;
        val_reg     <= val_next;
        lq_reg      <= lq_next;
        rq_reg      <= rq_next;
        load_reg    <= load_next;
        phase2_reg  <= phase2_next;
        rem_reg     <= rem_next;
        bad_reg     <= bad_next;
        m_total_reg <= m_total_next;
        m_bad_reg   <= m_bad_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_total_reg;
    assign m_tuser[0] = m_bad_reg;

endmodule
`default_nettype wire
